FILE: hw/rtl/weighted_l1_bubble_test_defines.svh
// Assertion macros shared by the weighted L1 bubble test RTL.
`ifndef WEIGHTED_L1_BUBBLE_TEST_DEFINES_SVH
`define WEIGHTED_L1_BUBBLE_TEST_DEFINES_SVH

// Clocked property check, off while reset is asserted
`define WL1B_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge
`define WL1B_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/wl1b_pkg.sv
// Package: register map and fixed widths of the weighted L1 bubble test.
`default_nettype none
package wl1b_pkg;
  localparam int unsigned MAX_AXES   = 4;
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned EXTENT_W   = 31;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_0 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_1 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_2 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_3 = 3'd7;

  localparam logic [EXTENT_W-1:0] EXTENT_RESET = 31'd65536;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [EXTENT_W-1:0] extent_t;
endpackage
`default_nettype wire

FILE: hw/rtl/wl1b_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none
module wl1b_div #(
  parameter int unsigned NW  = 48,
  parameter int unsigned DW  = 31,
  parameter int unsigned SBW = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           vld_i,
  input  wire logic [NW-1:0]  num_i,
  input  wire logic [DW-1:0]  den_i,
  input  wire logic [SBW-1:0] side_i,
  output logic                vld_o,
  output logic [NW-1:0]       quo_o,
  output logic [SBW-1:0]      side_o
);
  logic           st_vld  [NW+1];
  logic [DW-1:0]  st_rem  [NW+1];
  logic [NW-1:0]  st_num  [NW+1];
  logic [NW-1:0]  st_quo  [NW+1];
  logic [DW-1:0]  st_den  [NW+1];
  logic [SBW-1:0] st_side [NW+1];

  assign st_vld[0]  = vld_i;
  assign st_rem[0]  = '0;
  assign st_num[0]  = num_i;
  assign st_quo[0]  = '0;
  assign st_den[0]  = den_i;
  assign st_side[0] = side_i;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0]    trial;
    logic [DW:0]    sub;
    logic           ge;
    logic           vld_q;
    logic [DW-1:0]  rem_q;
    logic [NW-1:0]  num_q;
    logic [NW-1:0]  quo_q;
    logic [DW-1:0]  den_q;
    logic [SBW-1:0] side_q;

    // shift in next numerator bit, subtract divisor when it fits
    assign trial = {st_rem[k], st_num[k][NW-1]};
    assign ge    = trial >= {1'b0, st_den[k]};
    assign sub   = trial - {1'b0, st_den[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= st_vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= ge ? sub[DW-1:0] : trial[DW-1:0];
        num_q  <= {st_num[k][NW-2:0], 1'b0};
        quo_q  <= {st_quo[k][NW-2:0], ge};
        den_q  <= st_den[k];
        side_q <= st_side[k];
      end
    end

    assign st_vld[k+1]  = vld_q;
    assign st_rem[k+1]  = rem_q;
    assign st_num[k+1]  = num_q;
    assign st_quo[k+1]  = quo_q;
    assign st_den[k+1]  = den_q;
    assign st_side[k+1] = side_q;
  end

  assign vld_o  = st_vld[NW];
  assign quo_o  = st_quo[NW];
  assign side_o = st_side[NW];
endmodule
`default_nettype wire

FILE: hw/rtl/weighted_l1_bubble_test.sv
// Path of an item: entry stage, first divider bank, sum stage, second divider bank, output stage.
// Throughput: one item per cycle while the output is not stalled; each divider retires one quotient bit per stage.
// A stall at the output freezes the whole pipeline; nothing is dropped or repeated.
// Reset: asynchronous, active low; clears valid bits, centres to 0, extents to 1.0.
// Two divider banks: per-axis term (offset/extent), then hull offset (offset/sum).
`default_nettype none
module weighted_l1_bubble_test #(
  parameter int unsigned AXES      = 4,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [wl1b_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [wl1b_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                        valid_i,
  output logic                             stall_o,
  input  wire logic [31:0]                 query_c0_i,
  input  wire logic [31:0]                 query_c1_i,
  input  wire logic [31:0]                 query_c2_i,
  input  wire logic [31:0]                 query_c3_i,
  output logic                             valid_o,
  input  wire logic                        stall_i,
  output logic                             inside_res_o,
  output logic [31:0]                      weighted_norm_o,
  output logic [31:0]                      hull_c0_o,
  output logic [31:0]                      hull_c1_o,
  output logic [31:0]                      hull_c2_o,
  output logic [31:0]                      hull_c3_o,
  output logic                             degenerate_o
);
  import wl1b_pkg::*;

  localparam int unsigned N1  = 32 + FRAC_BITS;   // dividend width
  localparam int unsigned SW  = N1 + 2;           // sum width
  localparam int unsigned HW  = N1 + 2;           // hull add width
  localparam int unsigned SB1 = 32 + 1 + 32;
  localparam int unsigned SB2 = 32 + 1 + 1 + 1 + 32;

  logic en;
  logic out_vld_q;

  // whole pipeline advances unless the result is held
  assign en      = !(out_vld_q && stall_i);
  assign stall_o = !en;

  // configuration registers
  coord_t  centre_q [MAX_AXES];
  extent_t extent_q [MAX_AXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_AXES; i++) begin
        centre_q[i] <= '0;
        extent_q[i] <= EXTENT_RESET;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CENTRE_0: centre_q[0] <= cfg_data_i;
        CFG_CENTRE_1: centre_q[1] <= cfg_data_i;
        CFG_CENTRE_2: centre_q[2] <= cfg_data_i;
        CFG_CENTRE_3: centre_q[3] <= cfg_data_i;
        CFG_EXTENT_0: extent_q[0] <= cfg_data_i[EXTENT_W-1:0];
        CFG_EXTENT_1: extent_q[1] <= cfg_data_i[EXTENT_W-1:0];
        CFG_EXTENT_2: extent_q[2] <= cfg_data_i[EXTENT_W-1:0];
        CFG_EXTENT_3: extent_q[3] <= cfg_data_i[EXTENT_W-1:0];
        default: ;
      endcase
    end
  end

  coord_t query [MAX_AXES];
  assign query[0] = query_c0_i;
  assign query[1] = query_c1_i;
  assign query[2] = query_c2_i;
  assign query[3] = query_c3_i;

  // entry stage: offset magnitude and sign
  logic    e_vld_q;
  logic [31:0] e_mag_q [MAX_AXES];
  logic    e_neg_q [MAX_AXES];
  coord_t  e_ctr_q [MAX_AXES];
  extent_t e_ext_q [MAX_AXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (en) begin
      e_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [32:0] diff;
    if (en) begin
      for (int i = 0; i < MAX_AXES; i++) begin
        diff = {query[i][31], query[i]} - {centre_q[i][31], centre_q[i]};
        e_neg_q[i] <= diff[32];
        e_mag_q[i] <= diff[32] ? 32'(-diff) : diff[31:0];
        e_ctr_q[i] <= centre_q[i];
        // zero extent behaves as the smallest extent
        e_ext_q[i] <= (extent_q[i] == '0) ? EXTENT_W'(1) : extent_q[i];
      end
    end
  end

  // first divider bank: per-axis term
  logic          d1_vld  [MAX_AXES];
  logic [N1-1:0] d1_quo  [MAX_AXES];
  logic [SB1-1:0] d1_side [MAX_AXES];

  for (genvar i = 0; i < MAX_AXES; i++) begin : g_div1
    if (i < AXES) begin : g_on
      wl1b_div #(.NW(N1), .DW(EXTENT_W), .SBW(SB1)) u_div (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en),
        .vld_i  (e_vld_q),
        .num_i  ({e_mag_q[i], FRAC_BITS'(0)}),
        .den_i  (e_ext_q[i]),
        .side_i ({e_ctr_q[i], e_neg_q[i], e_mag_q[i]}),
        .vld_o  (d1_vld[i]),
        .quo_o  (d1_quo[i]),
        .side_o (d1_side[i])
      );
    end else begin : g_off
      assign d1_vld[i]  = 1'b0;
      assign d1_quo[i]  = '0;
      assign d1_side[i] = '0;
    end
  end

  // sum stage
  logic          s_vld_q;
  logic [SW-1:0] s_sum_q;
  logic [31:0]   s_mag_q [MAX_AXES];
  logic          s_neg_q [MAX_AXES];
  coord_t        s_ctr_q [MAX_AXES];
  logic [SW-1:0] sum_d;

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < MAX_AXES; i++) begin
      sum_d = sum_d + SW'(d1_quo[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
    end else if (en) begin
      s_vld_q <= d1_vld[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_sum_q <= sum_d;
      for (int i = 0; i < MAX_AXES; i++) begin
        s_ctr_q[i] <= d1_side[i][64:33];
        s_neg_q[i] <= d1_side[i][32];
        s_mag_q[i] <= d1_side[i][31:0];
      end
    end
  end

  // flags from the unsaturated sum
  logic        s_zero;
  logic        s_inside;
  logic [31:0] s_norm;
  assign s_zero   = (s_sum_q == '0);
  assign s_inside = s_sum_q < (SW'(1) << FRAC_BITS);
  assign s_norm   = (|s_sum_q[SW-1:32]) ? 32'hFFFF_FFFF : s_sum_q[31:0];

  // second divider bank: hull offset
  logic          d2_vld  [MAX_AXES];
  logic [N1-1:0] d2_quo  [MAX_AXES];
  logic [SB2-1:0] d2_side [MAX_AXES];

  for (genvar i = 0; i < MAX_AXES; i++) begin : g_div2
    if (i < AXES) begin : g_on
      wl1b_div #(.NW(N1), .DW(SW), .SBW(SB2)) u_div (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en),
        .vld_i  (s_vld_q),
        .num_i  ({s_mag_q[i], FRAC_BITS'(0)}),
        .den_i  (s_sum_q),
        .side_i ({s_ctr_q[i], s_neg_q[i], s_zero, s_inside, s_norm}),
        .vld_o  (d2_vld[i]),
        .quo_o  (d2_quo[i]),
        .side_o (d2_side[i])
      );
    end else begin : g_off
      assign d2_vld[i]  = 1'b0;
      assign d2_quo[i]  = '0;
      assign d2_side[i] = '0;
    end
  end

  // output stage: signed add and saturate
  // side word: centre [66:35], sign [34], zero [33], inside [32], norm [31:0]
  localparam logic signed [HW-1:0] SMAX = $signed({{(HW-32){1'b0}}, 32'h7FFF_FFFF});
  localparam logic signed [HW-1:0] SMIN = $signed({{(HW-32){1'b1}}, 32'h8000_0000});

  logic        out_inside_q;
  logic        out_zero_q;
  logic [31:0] out_norm_q;
  coord_t      out_hull_q [MAX_AXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d2_vld[0];
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [HW-1:0] cext;
    logic signed [HW-1:0] qv;
    logic signed [HW-1:0] t;
    if (en) begin
      out_zero_q   <= d2_side[0][33];
      out_inside_q <= d2_side[0][32];
      out_norm_q   <= d2_side[0][31:0];
      for (int i = 0; i < MAX_AXES; i++) begin
        cext = $signed({{(HW-32){d2_side[i][66]}}, d2_side[i][66:35]});
        qv   = $signed({2'b00, d2_quo[i]});
        t    = d2_side[i][34] ? (cext - qv) : (cext + qv);
        if (i >= AXES) begin
          out_hull_q[i] <= '0;
        end else if (d2_side[i][33]) begin
          out_hull_q[i] <= d2_side[i][66:35];
        end else if (t > SMAX) begin
          out_hull_q[i] <= 32'h7FFF_FFFF;
        end else if (t < SMIN) begin
          out_hull_q[i] <= 32'h8000_0000;
        end else begin
          out_hull_q[i] <= t[31:0];
        end
      end
    end
  end

  assign valid_o         = out_vld_q;
  assign inside_res_o    = out_inside_q;
  assign weighted_norm_o = out_norm_q;
  assign degenerate_o    = out_zero_q;
  assign hull_c0_o       = out_hull_q[0];
  assign hull_c1_o       = out_hull_q[1];
  assign hull_c2_o       = out_hull_q[2];
  assign hull_c3_o       = out_hull_q[3];

`include "weighted_l1_bubble_test_defines.svh"

  `WL1B_ASSERT(a_degen_flags, valid_o && degenerate_o |-> inside_res_o && weighted_norm_o == 32'd0, "degenerate result without inside and zero norm")
  `WL1B_ASSERT(a_inside_norm, valid_o && inside_res_o |-> weighted_norm_o < (32'd1 << FRAC_BITS), "inside flag with norm of one or more")
  `WL1B_ASSERT(a_held_result, valid_o && stall_i |=> valid_o && $stable(weighted_norm_o), "held result lost")
  `WL1B_NEVER(a_stall_idle, stall_o && !valid_o, "input stalled with empty output")
endmodule
`default_nettype wire
